/* design/ccrs_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the comparison-count rank sorter.
// No dependencies; used by the interfaces, the top level and the testbench.
package ccrs_pkg;

  localparam int unsigned MaxElementsDefault = 16;
  localparam int unsigned ValueW             = 32;

  typedef enum logic [2:0] {
    StIdle,
    StLoadRd,
    StLoadCmp,
    StLoadWr,
    StEmitRd,
    StEmitChk
  } state_e;

endpackage

/* design/ccrs_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the rank sorter: input, result and config.
// Depends on ccrs_pkg for the value width.
interface ccrs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ccrs_pkg::ValueW-1:0]   value;
  logic                                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ccrs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ccrs_pkg::ValueW-1:0]   value_res;
  logic                                 last_res;
  logic                                 dropped;

  modport source (output valid, output value_res, output last_res, output dropped,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input dropped,
                  output ready);
endinterface

interface ccrs_cfg_if;
  logic valid;
  logic ready;
  logic descending;

  modport source (output valid, output descending, input ready);
  modport sink   (input valid, input descending, output ready);
endinterface

/* design/comparison_count_rank_sorter.sv */
`timescale 1ns / 1ps
// Rank sorter top level: sequencer, shared comparator, element and rank RAMs.
// Depends on ccrs_pkg, the ccrs_*_if interfaces and ccrs_ram.
//
// Values are taken one request at a time; the block holds in_i.ready low while
// it works. A new value is compared against every stored value by one shared
// signed comparator, one stored entry at a time (RAM read, then compare and
// rank update). After a request marked last, results come out by scanning rank
// r over all stored entries, with a RAM read and a rank check per (rank, entry)
// pair; the scan holds on a matching entry while the sink holds out_o.ready low.
// Requests beyond MaxElements are discarded and every result of that sequence
// has dropped set. The descending bit may be written at any time the block is
// idle.
module comparison_count_rank_sorter #(
  parameter int unsigned MaxElements = ccrs_pkg::MaxElementsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccrs_in_if.sink    in_i,
  ccrs_out_if.source out_o,
  ccrs_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = $clog2(MaxElements);
  localparam int unsigned CntW = $clog2(MaxElements + 1);
  localparam int unsigned ValW = ccrs_pkg::ValueW;

  ccrs_pkg::state_e state_q, state_d;

  logic signed [ValW-1:0] val_q, val_d;
  logic                   last_q, last_d;
  logic                   desc_q;
  logic [CntW-1:0]        fill_q, fill_d;
  logic                   ovf_q, ovf_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [IdxW-1:0]        acc_q, acc_d;
  logic [IdxW-1:0]        rank_q, rank_d;
  logic [IdxW-1:0]        nout_q, nout_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [ValW-1:0] out_val_q, out_val_d;
  logic                   out_last_q, out_last_d;
  logic                   out_drop_q, out_drop_d;

  // RAM ports
  logic                   elem_we, rd_en, rank_we;
  logic [IdxW-1:0]        elem_waddr, rank_waddr;
  logic [IdxW-1:0]        rank_wdata;
  logic [ValW-1:0]        elem_rdata;
  logic [IdxW-1:0]        rank_rdata;

  logic            in_fire, out_free, is_full, cmp_later, rank_hit, idx_end, emit_end;
  logic [IdxW-1:0] slot;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign is_full  = (fill_q == CntW'(MaxElements));
  assign slot     = fill_q[IdxW-1:0];
  assign idx_end  = (CntW'(idx_q) + CntW'(1)) == fill_q;
  assign emit_end = (CntW'(nout_q) + CntW'(1)) == fill_q;
  assign rank_hit = (rank_rdata == rank_q);

  // Shared comparator: does the stored entry belong after the new value?
  assign cmp_later = desc_q ? (val_q > $signed(elem_rdata))
                            : ($signed(elem_rdata) > val_q);

  assign in_i.ready      = (state_q == ccrs_pkg::StIdle);
  assign cfg_i.ready     = (state_q == ccrs_pkg::StIdle);
  assign out_o.valid     = out_valid_q;
  assign out_o.value_res = out_val_q;
  assign out_o.last_res  = out_last_q;
  assign out_o.dropped   = out_drop_q;

  ccrs_ram #(.Width(ValW), .Depth(MaxElements)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_waddr),
    .wdata_i (in_i.value),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (elem_rdata)
  );

  ccrs_ram #(.Width(IdxW), .Depth(MaxElements)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (rank_wdata),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (rank_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ccrs_pkg::StIdle: begin
        if (in_fire) begin
          if (is_full) begin
            state_d = in_i.last ? ccrs_pkg::StEmitRd : ccrs_pkg::StIdle;
          end else if (fill_q == '0) begin
            state_d = ccrs_pkg::StLoadWr;
          end else begin
            state_d = ccrs_pkg::StLoadRd;
          end
        end
      end
      ccrs_pkg::StLoadRd:  state_d = ccrs_pkg::StLoadCmp;
      ccrs_pkg::StLoadCmp: state_d = idx_end ? ccrs_pkg::StLoadWr : ccrs_pkg::StLoadRd;
      ccrs_pkg::StLoadWr:  state_d = last_q ? ccrs_pkg::StEmitRd : ccrs_pkg::StIdle;
      ccrs_pkg::StEmitRd:  state_d = ccrs_pkg::StEmitChk;
      ccrs_pkg::StEmitChk: begin
        if (!rank_hit) begin
          state_d = ccrs_pkg::StEmitRd;
        end else if (out_free) begin
          state_d = emit_end ? ccrs_pkg::StIdle : ccrs_pkg::StEmitRd;
        end
      end
      default: state_d = ccrs_pkg::StIdle;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    val_d       = val_q;
    last_d      = last_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    rank_d      = rank_q;
    nout_d      = nout_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    elem_we     = 1'b0;
    elem_waddr  = slot;
    rd_en       = 1'b0;
    rank_we     = 1'b0;
    rank_waddr  = idx_q;
    rank_wdata  = rank_rdata + IdxW'(1);

    case (state_q)
      ccrs_pkg::StIdle: begin
        if (in_fire) begin
          val_d  = in_i.value;
          last_d = in_i.last;
          idx_d  = '0;
          acc_d  = '0;
          rank_d = '0;
          nout_d = '0;
          if (is_full) begin
            ovf_d = 1'b1;
          end else begin
            elem_we = 1'b1;
          end
        end
      end
      ccrs_pkg::StLoadRd: begin
        rd_en = 1'b1;
      end
      ccrs_pkg::StLoadCmp: begin
        if (cmp_later) begin
          rank_we = 1'b1;
        end else begin
          acc_d = acc_q + IdxW'(1);
        end
        idx_d = idx_q + IdxW'(1);
      end
      ccrs_pkg::StLoadWr: begin
        rank_we    = 1'b1;
        rank_waddr = slot;
        rank_wdata = acc_q;
        fill_d     = fill_q + CntW'(1);
        idx_d      = '0;
        rank_d     = '0;
        nout_d     = '0;
      end
      ccrs_pkg::StEmitRd: begin
        rd_en = 1'b1;
      end
      ccrs_pkg::StEmitChk: begin
        if (!rank_hit || out_free) begin
          // advance the scan: next entry, or wrap to the next rank
          if (idx_end) begin
            idx_d  = '0;
            rank_d = rank_q + IdxW'(1);
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
        if (rank_hit && out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = $signed(elem_rdata);
          out_last_d  = emit_end;
          out_drop_d  = ovf_q;
          nout_d      = nout_q + IdxW'(1);
          if (emit_end) begin
            fill_d = '0;
            ovf_d  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccrs_pkg::StIdle;
      desc_q      <= 1'b0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      acc_q       <= '0;
      rank_q      <= '0;
      nout_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      rank_q      <= rank_d;
      nout_q      <= nout_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      if (cfg_i.valid && cfg_i.ready) begin
        desc_q <= cfg_i.descending;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

endmodule

/* design/ccrs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ccrs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* test/tb_comparison_count_rank_sorter.sv */
`timescale 1ns / 1ps
// Self-checking bench for the rank sorter: loads value sequences, predicts the sorted output
// stream per sequence and compares every result; depends on ccrs_pkg, the ccrs_*_if
// interfaces and comparison_count_rank_sorter.
module tb_comparison_count_rank_sorter;

  localparam int unsigned Capacity        = ccrs_pkg::MaxElementsDefault;
  localparam int unsigned ValueW          = ccrs_pkg::ValueW;
  localparam int unsigned SettleCycles    = 2 * Capacity + 8;
  localparam int unsigned StallCycles     = 600;
  localparam int unsigned ErrorPrintLimit = 100;
  localparam logic signed [ValueW-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] MaxValue = 32'sh7fff_ffff;

  typedef struct {
    logic signed [ValueW-1:0] value_res;
    logic                     last_res;
    logic                     dropped;
  } sorted_item_t;

  logic clk_i;
  logic rst_ni;

  ccrs_in_if  in_if ();
  ccrs_out_if out_if ();
  ccrs_cfg_if cfg_if ();

  comparison_count_rank_sorter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predicted block state
  logic signed [ValueW-1:0] held_value [Capacity];
  logic [4:0]               held_rank  [Capacity];
  logic [4:0]               held_count;
  logic                     overflowed;
  logic                     descending_cfg;

  sorted_item_t sorted_expected [$];
  int unsigned  fail_count;
  bit           no_idle;
  logic         hold_results;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void clear_sequence();
    for (int i = 0; i < Capacity; i++) begin
      held_value[i] = '0;
      held_rank[i]  = '0;
    end
    held_count = '0;
    overflowed = 1'b0;
  endfunction

  // Rank the new value against every held one; on last, queue the sorted stream.
  function automatic void rank_insert(input logic signed [ValueW-1:0] v, input logic lst);
    int unsigned  slot;
    int unsigned  emitted;
    logic         held_is_later;
    sorted_item_t item;
    if (held_count < Capacity) begin
      slot = held_count;
      for (int i = 0; i < slot; i++) begin
        held_is_later = descending_cfg ? (v > held_value[i]) : (held_value[i] > v);
        if (held_is_later) held_rank[i]++;
        else held_rank[slot]++;
      end
      held_value[slot] = v;
      held_count++;
    end else begin
      overflowed = 1'b1;
    end
    if (!lst) return;
    emitted = 0;
    // Equal ranks (after a direction change) go out in arrival order.
    for (int r = 0; r < held_count; r++) begin
      for (int i = 0; i < held_count; i++) begin
        if (held_rank[i] == r) begin
          item.value_res = held_value[i];
          item.last_res  = (emitted == held_count - 1);
          item.dropped   = overflowed;
          sorted_expected.push_back(item);
          emitted++;
        end
      end
    end
    clear_sequence();
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned mode;
    mode = $urandom_range(9);
    if (mode < 5) return $urandom;
    if (mode < 8) return $signed($urandom_range(6)) - 3;
    case ($urandom_range(3))
      0: return MinValue;
      1: return MaxValue;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [ValueW-1:0] want,
                             input logic signed [ValueW-1:0] got);
    if (got !== want) begin
      fail_count++;
      // quiet after the first hundred
      if (fail_count <= ErrorPrintLimit)
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  initial begin : result_monitor
    sorted_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (sorted_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= ErrorPrintLimit)
            $error("unexpected result: value_res %0d, last_res %0b, dropped %0b",
                   out_if.value_res, out_if.last_res, out_if.dropped);
        end else begin
          want = sorted_expected.pop_front();
          check_field("value_res", want.value_res, out_if.value_res);
          check_field("last_res", ValueW'(want.last_res), ValueW'(out_if.last_res));
          check_field("dropped", ValueW'(want.dropped), ValueW'(out_if.dropped));
        end
      end
      if (hold_results) begin
        out_if.ready <= 1'b0;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic send_value(input logic signed [ValueW-1:0] v, input logic lst);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    rank_insert(v, lst);
  endtask

  // Drop the request, wait for every result, then let any compare pass finish.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sorted_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_direction(input logic desc);
    wait_drained();
    cfg_if.valid      <= 1'b1;
    cfg_if.descending <= desc;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid   <= 1'b0;
    descending_cfg = desc;
  endtask

  task automatic send_sequence(input int unsigned len);
    for (int k = 0; k < len; k++) send_value(pick_value(), k == len - 1);
  endtask

  task automatic test_extremes_ascending();
    set_direction(1'b0);
    send_value(MaxValue, 1'b0);
    send_value(MinValue, 1'b0);
    send_value('0, 1'b0);
    send_value(-1, 1'b0);
    send_value('0, 1'b1);
  endtask

  task automatic test_single_element();
    set_direction(1'b1);
    send_value(MinValue, 1'b1);
  endtask

  task automatic test_direction_flip();
    set_direction(1'b0);
    send_value(MaxValue, 1'b0);
    send_value(1, 1'b0);
    set_direction(1'b1);
    send_value(MinValue, 1'b0);
    send_value(-1, 1'b1);
  endtask

  // Seventeenth value lands past capacity and carries last.
  task automatic test_overflow();
    set_direction(1'b1);
    for (int k = 0; k < Capacity; k++) send_value(pick_value(), 1'b0);
    send_value(MaxValue, 1'b1);
  endtask

  task automatic test_random_sequences(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned flip_at;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(Capacity + 4, Capacity + 1)
                                     : $urandom_range(Capacity, 1);
      if ($urandom_range(2) == 0) set_direction(1'($urandom_range(1)));
      flip_at = (len > 2 && $urandom_range(7) == 0) ? $urandom_range(len - 1, 1) : 0;
      for (int k = 0; k < len; k++) begin
        if (flip_at != 0 && k == flip_at) set_direction(!descending_cfg);
        send_value(pick_value(), k == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (3) send_sequence($urandom_range(Capacity, 10));
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Hold the result side while further requests keep coming.
  task automatic test_output_backpressure();
    set_direction(1'($urandom_range(1)));
    fork
      begin
        hold_results <= 1'b1;
        repeat (StallCycles) @(posedge clk_i);
        hold_results <= 1'b0;
      end
    join_none
    send_sequence(12);
    send_sequence(8);
    wait_drained();
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.value       = '0;
    in_if.last        = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.descending = 1'b0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    descending_cfg    = 1'b0;
    no_idle           = 1'b0;
    hold_results      = 1'b0;
    fail_count        = 0;
    clear_sequence();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes_ascending();
    test_single_element();
    test_direction_flip();
    test_overflow();
    test_random_sequences(300);
    test_back_to_back();
    test_output_backpressure();
    wait_drained();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/ccrs_pkg.sv
design/ccrs_if.sv
design/ccrs_ram.sv
design/comparison_count_rank_sorter.sv
test/tb_comparison_count_rank_sorter.sv
